FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SRS_ASSERT_IMP(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define SRS_ASSERT_NXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: hw/rtl/srs_pkg.sv
package srs_pkg;

  // Field widths
  localparam int VALUE_W     = 64;
  localparam int OUTER_W     = 32;
  // Trial divisors stay below the cube root of a 64-bit value
  localparam int DIVISOR_W   = 22;
  localparam int DSQ_W       = 2 * DIVISOR_W;
  localparam int DIV_REM_W   = DIVISOR_W;
  localparam int DIV_CNT_W   = $clog2(VALUE_W);
  // Square root: two value bits per step
  localparam int SQ_STEPS    = VALUE_W / 2;
  localparam int SQ_CNT_W    = $clog2(SQ_STEPS);
  localparam int SQ_REM_W    = OUTER_W + 1;

  // First two trial divisors
  localparam logic [DIVISOR_W-1:0] D_FIRST  = DIVISOR_W'(2);
  localparam logic [DIVISOR_W-1:0] D_SECOND = DIVISOR_W'(3);
  localparam logic [DIVISOR_W-1:0] D_STEP   = DIVISOR_W'(2);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_START,
    S_DIV_WAIT,
    S_NEXT_D,
    S_MUL_START,
    S_MUL_WAIT,
    S_SQRT_START,
    S_SQRT,
    S_SQRT_END,
    S_DONE
  } srs_state_t;

  typedef enum logic [1:0] {
    MUL_OUTER_D,
    MUL_RAD_D,
    MUL_OUTER_S,
    MUL_RAD_M
  } srs_mul_op_t;

  typedef struct packed {
    logic                 start;
    logic [VALUE_W-1:0]   dividend;
    logic [DIVISOR_W-1:0] divisor;
  } srs_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [VALUE_W-1:0]   quotient;
    logic [DIV_REM_W-1:0] remainder;
  } srs_div_rsp_t;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] mcand;
    logic [VALUE_W-1:0] mplier;
  } srs_mul_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] product;
  } srs_mul_rsp_t;

endpackage

FILE: hw/rtl/srs_in_if.sv
interface srs_in_if import srs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               negative;

  modport source (output valid, output value, output negative, input ready);
  modport sink (input valid, input value, input negative, output ready);
endinterface

FILE: hw/rtl/srs_out_if.sv
interface srs_out_if import srs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OUTER_W-1:0] outer_factor;
  logic [VALUE_W-1:0] radical;
  logic               imaginary;

  modport source (output valid, output outer_factor, output radical, output imaginary,
                  input ready);
  modport sink (input valid, input outer_factor, input radical, input imaginary,
                output ready);
endinterface

FILE: hw/rtl/square_root_simplifier_top.sv
// Sequence: a zero input goes straight to the result; otherwise trial divisions run on a bit-serial
//   divider (one quotient bit a cycle), multiplies on a shift-add unit, then the final root.
// Worst case is set by trial divisors up to the cube root of the value.
// Flow: one item at a time; the next item is accepted while a result waits.
// Reset: synchronous, active low; clears the sequencer and empties the result register.
module square_root_simplifier_top import srs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  srs_in_if.sink    in_ch,
  srs_out_if.source out_ch
);

  localparam logic [SQ_CNT_W-1:0] SQ_LAST = SQ_CNT_W'(SQ_STEPS - 1);

  srs_state_t           state_r, state_nxt;
  srs_mul_op_t          mul_op_r;
  logic [VALUE_W-1:0]   m_r;
  logic [OUTER_W-1:0]   outer_r;
  logic [VALUE_W-1:0]   rad_r;
  logic                 imag_r;
  logic [DIVISOR_W-1:0] d_r;
  logic [DSQ_W-1:0]     dsq_r;
  logic                 first_r;
  logic                 e_odd_r;

  logic [VALUE_W-1:0]   sq_src_r;
  logic [SQ_REM_W-1:0]  sq_rem_r;
  logic [OUTER_W-1:0]   sq_root_r;
  logic [SQ_CNT_W-1:0]  sq_cnt_r;

  logic                 out_valid_r;
  logic [OUTER_W-1:0]   out_outer_r;
  logic [VALUE_W-1:0]   out_rad_r;
  logic                 out_imag_r;

  srs_div_req_t         div_req;
  srs_div_rsp_t         div_rsp;
  srs_mul_req_t         mul_req;
  srs_mul_rsp_t         mul_rsp;

  logic                 in_fire;
  logic                 out_load;
  logic                 loop_exit;
  logic                 div_exact;
  logic                 mul_to_outer;
  logic [SQ_REM_W+1:0]  sq_rem_sh;
  logic [SQ_REM_W+1:0]  sq_trial;
  logic [SQ_REM_W+1:0]  sq_diff;
  logic                 sq_ge;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_load     = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign loop_exit    = first_r && ({{(VALUE_W-DSQ_W){1'b0}}, dsq_r} > div_rsp.quotient);
  assign div_exact    = div_rsp.remainder == '0;
  assign mul_to_outer = (mul_op_r == MUL_OUTER_D) || (mul_op_r == MUL_OUTER_S);

  // Square root step: bring in two bits, try to subtract 4*root+1
  assign sq_rem_sh = {sq_rem_r, sq_src_r[VALUE_W-1 -: 2]};
  assign sq_trial  = {1'b0, sq_root_r, 2'b01};
  assign sq_diff   = sq_rem_sh - sq_trial;
  assign sq_ge     = sq_rem_sh >= sq_trial;

  srs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  srs_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_ch.value == '0) ? S_DONE : S_DIV_START;
        end
      end
      S_DIV_START: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          priority if (loop_exit) begin
            state_nxt = S_SQRT_START;
          end else if (e_odd_r) begin
            state_nxt = S_MUL_START;
          end else if (div_exact) begin
            state_nxt = S_DIV_START;
          end else begin
            state_nxt = S_NEXT_D;
          end
        end
      end
      S_NEXT_D:    state_nxt = S_DIV_START;
      S_MUL_START: state_nxt = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (mul_rsp.done) begin
          unique case (mul_op_r)
            MUL_OUTER_D: state_nxt = S_DIV_START;
            MUL_RAD_D:   state_nxt = S_NEXT_D;
            MUL_OUTER_S: state_nxt = S_DONE;
            MUL_RAD_M:   state_nxt = S_DONE;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_SQRT_START: state_nxt = (m_r > VALUE_W'(1)) ? S_SQRT : S_DONE;
      S_SQRT: begin
        if (sq_cnt_r == SQ_LAST) begin
          state_nxt = S_SQRT_END;
        end
      end
      S_SQRT_END: state_nxt = S_MUL_START;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake and unit requests
  always_comb begin
    in_ch.ready      = (state_r == S_IDLE);
    div_req.start    = (state_r == S_DIV_START);
    div_req.dividend = m_r;
    div_req.divisor  = d_r;
    mul_req.start    = (state_r == S_MUL_START);
    mul_req.mcand    = mul_to_outer ? VALUE_W'(outer_r) : rad_r;
    unique case (mul_op_r)
      MUL_OUTER_D: mul_req.mplier = VALUE_W'(d_r);
      MUL_RAD_D:   mul_req.mplier = VALUE_W'(d_r);
      MUL_OUTER_S: mul_req.mplier = VALUE_W'(sq_root_r);
      MUL_RAD_M:   mul_req.mplier = m_r;
      default:     mul_req.mplier = m_r;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          m_r     <= in_ch.value;
          imag_r  <= in_ch.negative && (in_ch.value != '0);
          outer_r <= (in_ch.value == '0) ? '0 : OUTER_W'(1);
          rad_r   <= VALUE_W'(1);
          d_r     <= D_FIRST;
          dsq_r   <= DSQ_W'(D_FIRST) * DSQ_W'(D_FIRST);
          first_r <= 1'b1;
          e_odd_r <= 1'b0;
        end
      end
      S_DIV_WAIT: begin
        if (div_rsp.done && !loop_exit) begin
          first_r <= 1'b0;
          if (div_exact) begin
            // Divide out one more factor; every second one goes outside
            m_r      <= div_rsp.quotient;
            e_odd_r  <= ~e_odd_r;
            mul_op_r <= MUL_OUTER_D;
          end else begin
            mul_op_r <= MUL_RAD_D;
          end
        end
      end
      S_NEXT_D: begin
        // Advance to the next trial divisor and its square
        first_r <= 1'b1;
        e_odd_r <= 1'b0;
        if (d_r == D_FIRST) begin
          d_r   <= D_SECOND;
          dsq_r <= DSQ_W'(D_SECOND) * DSQ_W'(D_SECOND);
        end else begin
          d_r   <= d_r + D_STEP;
          dsq_r <= dsq_r + DSQ_W'({d_r, 2'b00}) + DSQ_W'(4);
        end
      end
      S_MUL_WAIT: begin
        if (mul_rsp.done) begin
          if (mul_to_outer) begin
            outer_r <= mul_rsp.product[OUTER_W-1:0];
          end else begin
            rad_r <= mul_rsp.product;
          end
        end
      end
      S_SQRT_START: begin
        sq_src_r  <= m_r;
        sq_rem_r  <= '0;
        sq_root_r <= '0;
        sq_cnt_r  <= '0;
      end
      S_SQRT: begin
        sq_src_r  <= {sq_src_r[VALUE_W-3:0], 2'b00};
        sq_rem_r  <= sq_ge ? sq_diff[SQ_REM_W-1:0] : sq_rem_sh[SQ_REM_W-1:0];
        sq_root_r <= {sq_root_r[OUTER_W-2:0], sq_ge};
        sq_cnt_r  <= sq_cnt_r + SQ_CNT_W'(1);
      end
      S_SQRT_END: begin
        // Leftover is a prime square or joins the radical
        mul_op_r <= (sq_rem_r == '0) ? MUL_OUTER_S : MUL_RAD_M;
      end
      S_DIV_START, S_MUL_START, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_outer_r <= outer_r;
      out_rad_r   <= rad_r;
      out_imag_r  <= imag_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.outer_factor = out_outer_r;
  assign out_ch.radical      = out_rad_r;
  assign out_ch.imaginary    = out_imag_r;

endmodule

FILE: hw/rtl/srs_div.sv
module srs_div import srs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  srs_div_req_t req,
  output srs_div_rsp_t rsp
);

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(VALUE_W - 1);

  logic [VALUE_W-1:0]   dq_r;
  logic [DIV_REM_W-1:0] rem_r;
  logic [DIVISOR_W-1:0] dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIV_REM_W:0]   rem_sh;
  logic [DIV_REM_W:0]   diff;
  logic                 ge;

  // One quotient bit per cycle, restoring
  assign rem_sh = {rem_r, dq_r[VALUE_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == LAST_STEP) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Shift dividend out and quotient in
  always_ff @(posedge clk) begin
    if (req.start) begin
      dq_r  <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      dq_r  <= {dq_r[VALUE_W-2:0], ge};
      rem_r <= ge ? diff[DIV_REM_W-1:0] : rem_sh[DIV_REM_W-1:0];
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dq_r;
  assign rsp.remainder = rem_r;

endmodule

FILE: hw/rtl/srs_mul.sv
module srs_mul import srs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  srs_mul_req_t req,
  output srs_mul_rsp_t rsp
);

  logic [VALUE_W-1:0] mcand_r;
  logic [VALUE_W-1:0] mplier_r;
  logic [VALUE_W-1:0] acc_r;
  logic               busy_r;
  logic               done_r;

  // Control: finish once the multiplier bits run out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && mplier_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Shift-add, one multiplier bit per cycle, product kept modulo 2^64
  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand_r  <= req.mcand;
      mplier_r <= req.mplier;
      acc_r    <= '0;
    end else if (busy_r && mplier_r != '0) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= {mcand_r[VALUE_W-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[VALUE_W-1:1]};
    end
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule

FILE: hw/rtl/srs_checker.sv
`include "assert_macros.svh"

module srs_checker import srs_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [OUTER_W-1:0] out_outer_factor,
  input logic [VALUE_W-1:0] out_radical,
  input logic               out_imaginary
);

  // A pending result stays offered until taken
  `SRS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // Accepting an item makes the block busy
  `SRS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // The radical is never zero
  `SRS_ASSERT_IMP(a_rad_nonzero, clk, rst_n, out_valid, out_radical != '0)

  // A zero outer factor only comes from a zero value
  `SRS_ASSERT_IMP(a_zero_case, clk, rst_n, out_valid && (out_outer_factor == '0),
                  (out_radical == VALUE_W'(1)) && !out_imaginary)

endmodule

bind square_root_simplifier_top srs_checker u_srs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_outer_factor (out_ch.outer_factor),
  .out_radical      (out_ch.radical),
  .out_imaginary    (out_ch.imaginary)
);
